// ===== design/bsr_pkg.sv =====
package bsr_pkg;

   // fixed field widths
   localparam int VAL_W  = 32;
   localparam int SQ_W   = 64;
   localparam int ITER_W = 6;
   localparam int KIND_W = 2;
   localparam int PC_W   = 3;

   // register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_TOLERANCE = 1'b0;
   localparam logic [VAL_W-1:0] TOLERANCE_RESET = 32'd66;

   // result kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_TRACE = 2'd0,
      KIND_TOL   = 2'd1,
      KIND_EXACT = 2'd2,
      KIND_CAP   = 2'd3
   } kind_type;

   // datapath operations
   typedef enum logic [2:0] {
      OP_MUL_UP  = 3'd0,
      OP_MUL_EST = 3'd1,
      OP_DIFF    = 3'd2,
      OP_TEST    = 3'd3,
      OP_UPDATE  = 3'd4,
      OP_CAP     = 3'd5
   } op_type;

   // sequencing after a step
   typedef enum logic [1:0] {
      BR_NEXT,
      BR_END_IF_HIT,
      BR_LOOP_UNLESS_CAP,
      BR_END
   } br_type;

   // program addresses
   localparam logic [PC_W-1:0] PC_MUL_UP  = 3'd0;
   localparam logic [PC_W-1:0] PC_MUL_EST = 3'd1;
   localparam logic [PC_W-1:0] PC_DIFF    = 3'd2;
   localparam logic [PC_W-1:0] PC_TEST    = 3'd3;
   localparam logic [PC_W-1:0] PC_UPDATE  = 3'd4;
   localparam logic [PC_W-1:0] PC_CAP     = 3'd5;

   typedef struct packed {
      op_type          op;
      logic            emit;
      br_type          br;
      logic [PC_W-1:0] target;
   } uword_type;

   // sequencer to datapath
   typedef struct packed {
      logic   start;
      logic   fire;
      op_type op;
   } ctl_type;

   // datapath to sequencer
   typedef struct packed {
      logic hit;
      logic last_step;
      logic out_hold;
   } status_type;

   // control store
   function automatic uword_type ucode_rom(input logic [PC_W-1:0] pc);
      uword_type uw;
      case (pc)
         PC_MUL_UP:  uw = '{op: OP_MUL_UP,  emit: 1'b0, br: BR_NEXT,            target: PC_MUL_EST};
         PC_MUL_EST: uw = '{op: OP_MUL_EST, emit: 1'b0, br: BR_NEXT,            target: PC_DIFF};
         PC_DIFF:    uw = '{op: OP_DIFF,    emit: 1'b0, br: BR_NEXT,            target: PC_TEST};
         PC_TEST:    uw = '{op: OP_TEST,    emit: 1'b1, br: BR_END_IF_HIT,      target: PC_UPDATE};
         PC_UPDATE:  uw = '{op: OP_UPDATE,  emit: 1'b0, br: BR_LOOP_UNLESS_CAP, target: PC_MUL_EST};
         PC_CAP:     uw = '{op: OP_CAP,     emit: 1'b1, br: BR_END,             target: PC_MUL_UP};
         default:    uw = '{op: OP_CAP,     emit: 1'b1, br: BR_END,             target: PC_MUL_UP};
      endcase
      return uw;
   endfunction

endpackage

// ===== design/bsr_seq.sv =====
module bsr_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  bsr_pkg::status_type status,
   output bsr_pkg::ctl_type    ctl
);
   import bsr_pkg::*;

   logic            busy_ff, busy_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   uword_type       uw;
   logic            fire;
   logic            start;

   // one run at a time
   assign req_stall = busy_ff;
   assign start     = req_valid & ~busy_ff;

   // fetch and hold emitting steps while the result register is full and stalled
   assign uw   = ucode_rom(pc_ff);
   assign fire = busy_ff & ~(uw.emit & status.out_hold);

   assign ctl.start = start;
   assign ctl.fire  = fire;
   assign ctl.op    = uw.op;

   // next program address
   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (start) begin
         busy_in = 1'b1;
         pc_in   = PC_MUL_UP;
      end else if (fire) begin
         case (uw.br)
            BR_NEXT: begin
               pc_in = PC_W'(pc_ff + 1'b1);
            end
            BR_END_IF_HIT: begin
               if (status.hit) begin
                  busy_in = 1'b0;
               end else begin
                  pc_in = PC_W'(pc_ff + 1'b1);
               end
            end
            BR_LOOP_UNLESS_CAP: begin
               if (status.last_step) begin
                  pc_in = PC_W'(pc_ff + 1'b1);
               end else begin
                  pc_in = uw.target;
               end
            end
            BR_END: begin
               busy_in = 1'b0;
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= PC_MUL_UP;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

endmodule

// ===== design/bsr_dp.sv =====
module bsr_dp #(
   parameter int MAX_ITER  = 48,
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bsr_pkg::ctl_type                    ctl,
   input  logic [bsr_pkg::VAL_W-1:0]           req_value,
   input  logic [bsr_pkg::VAL_W-1:0]           tolerance,
   output bsr_pkg::status_type                 status,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bsr_pkg::KIND_W-1:0]          rsp_kind,
   output logic [bsr_pkg::ITER_W-1:0]          rsp_iteration,
   output logic [bsr_pkg::VAL_W-1:0]           rsp_low_bound,
   output logic [bsr_pkg::VAL_W-1:0]           rsp_midpoint,
   output logic [bsr_pkg::VAL_W-1:0]           rsp_high_bound,
   output logic [bsr_pkg::VAL_W-1:0]           rsp_root,
   output logic                                rsp_last
);
   import bsr_pkg::*;

   localparam logic [VAL_W-1:0]  ONE       = VAL_W'(1) << FRAC_BITS;
   localparam logic [ITER_W-1:0] LAST_STEP = ITER_W'(MAX_ITER - 1);

   // search state
   logic [VAL_W-1:0]  value_ff, lower_ff, upper_ff, est_ff;
   logic [SQ_W-1:0]   sq_lo_ff, sq_up_ff, sq_est_ff, diff_ff;
   logic              lt_ff;
   logic [ITER_W-1:0] step_ff;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   kind_type          kind_ff;
   logic [ITER_W-1:0] iter_ff;
   logic [VAL_W-1:0]  low_ff, mid_ff, high_ff, root_ff;
   logic              last_ff;

   logic [SQ_W-1:0]  target, tol;
   logic             hit_tol, hit_lo, hit_up;
   logic [VAL_W-1:0] first_upper, lower_nx, upper_nx;
   logic [VAL_W:0]   mid_sum;
   logic             act;
   logic [VAL_W-1:0] mul_op;
   logic [SQ_W-1:0]  mul_out;

   assign act = ctl.fire;

   // operands scaled to the square's fraction bits
   assign target = SQ_W'(value_ff) << FRAC_BITS;
   assign tol    = SQ_W'(tolerance) << FRAC_BITS;

   // one multiplier, squaring the upper bound or the estimate
   assign mul_op  = (ctl.op == OP_MUL_UP) ? upper_ff : est_ff;
   assign mul_out = SQ_W'(mul_op) * SQ_W'(mul_op);

   // end-of-run tests
   assign hit_tol = diff_ff <= tol;
   assign hit_lo  = sq_lo_ff == target;
   assign hit_up  = sq_up_ff == target;

   assign status.hit       = hit_tol | hit_lo | hit_up;
   assign status.last_step = step_ff == LAST_STEP;
   assign status.out_hold  = rsp_valid_ff & rsp_stall;

   // first upper bound, interval bounds after a step and the new midpoint
   assign first_upper = (req_value > ONE) ? req_value : ONE;
   assign lower_nx    = lt_ff ? est_ff : lower_ff;
   assign upper_nx    = lt_ff ? upper_ff : est_ff;
   assign mid_sum     = {1'b0, lower_nx} + {1'b0, upper_nx};

   // search datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= '0;
         upper_ff <= '0;
         est_ff   <= '0;
         step_ff  <= '0;
      end else if (ctl.start) begin
         value_ff <= req_value;
         lower_ff <= '0;
         upper_ff <= first_upper;
         est_ff   <= first_upper >> 1;
         sq_lo_ff <= '0;
         step_ff  <= '0;
      end else if (act) begin
         case (ctl.op)
            OP_MUL_UP: begin
               sq_up_ff <= mul_out;
            end
            OP_MUL_EST: begin
               sq_est_ff <= mul_out;
            end
            OP_DIFF: begin
               lt_ff   <= sq_est_ff < target;
               diff_ff <= (sq_est_ff < target) ? (target - sq_est_ff)
                                               : (sq_est_ff - target);
            end
            OP_UPDATE: begin
               lower_ff <= lower_nx;
               upper_ff <= upper_nx;
               if (lt_ff) begin
                  sq_lo_ff <= sq_est_ff;
               end else begin
                  sq_up_ff <= sq_est_ff;
               end
               est_ff  <= mid_sum[VAL_W:1];
               step_ff <= ITER_W'(step_ff + 1'b1);
            end
            default: begin
            end
         endcase
      end
   end

   // result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (act && (ctl.op == OP_TEST || ctl.op == OP_CAP)) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (act && (ctl.op == OP_TEST || ctl.op == OP_CAP)) begin
         iter_ff <= step_ff;
         low_ff  <= lower_ff;
         mid_ff  <= est_ff;
         high_ff <= upper_ff;
         if (ctl.op == OP_CAP) begin
            kind_ff <= KIND_CAP;
            root_ff <= est_ff;
            last_ff <= 1'b1;
         end else if (hit_tol) begin
            kind_ff <= KIND_TOL;
            root_ff <= est_ff;
            last_ff <= 1'b1;
         end else if (hit_lo) begin
            kind_ff <= KIND_EXACT;
            root_ff <= lower_ff;
            last_ff <= 1'b1;
         end else if (hit_up) begin
            kind_ff <= KIND_EXACT;
            root_ff <= upper_ff;
            last_ff <= 1'b1;
         end else begin
            kind_ff <= KIND_TRACE;
            root_ff <= '0;
            last_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_iteration  = iter_ff;
   assign rsp_low_bound  = low_ff;
   assign rsp_midpoint   = mid_ff;
   assign rsp_high_bound = high_ff;
   assign rsp_root       = root_ff;
   assign rsp_last       = last_ff;

endmodule

// ===== design/bisection_square_root.sv =====
// sequence: load, square the upper bound, then per bisection step square the estimate,
// take the difference, test and emit, and update the interval, over the one shared
// 32x32 multiplier; a cap result after MAX_ITER steps; one value at a time, emits wait on stalls
// reset: synchronous, active high; sequencer idle, result register empty, tolerance 66
module bisection_square_root #(
   parameter int MAX_ITER  = 48,
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [bsr_pkg::VAL_W-1:0]           req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bsr_pkg::KIND_W-1:0]          rsp_kind,
   output logic [bsr_pkg::ITER_W-1:0]          rsp_iteration,
   output logic [bsr_pkg::VAL_W-1:0]           rsp_low_bound,
   output logic [bsr_pkg::VAL_W-1:0]           rsp_midpoint,
   output logic [bsr_pkg::VAL_W-1:0]           rsp_high_bound,
   output logic [bsr_pkg::VAL_W-1:0]           rsp_root,
   output logic                                rsp_last,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bsr_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [bsr_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [bsr_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);
   import bsr_pkg::*;

   logic [VAL_W-1:0] tolerance_ff;
   logic             csr_write;
   logic             reg_index;
   ctl_type          ctl;
   status_type       status;

   // register file
   assign pready    = 1'b1;
   assign reg_index = paddr[2];
   assign csr_write = psel & penable & pwrite & pready;
   assign prdata    = (reg_index == REG_TOLERANCE) ? tolerance_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= TOLERANCE_RESET;
      end else if (csr_write && reg_index == REG_TOLERANCE) begin
         tolerance_ff <= pwdata;
      end
   end

   // microprogram sequencer
   bsr_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .ctl       (ctl)
   );

   // search datapath and result register
   bsr_dp #(
      .MAX_ITER  (MAX_ITER),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .req_value      (req_value),
      .tolerance      (tolerance_ff),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_iteration  (rsp_iteration),
      .rsp_low_bound  (rsp_low_bound),
      .rsp_midpoint   (rsp_midpoint),
      .rsp_high_bound (rsp_high_bound),
      .rsp_root       (rsp_root),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== tb/bisection_square_root_tb.sv =====
module bisection_square_root_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bsr_pkg::*;

   localparam int MAX_STEPS   = 48;
   localparam int FRAC        = 16;
   localparam int LONG_HOLD   = 300;
   localparam int DRAIN_WAIT  = 12;
   localparam int QUIET_LIMIT = 5000;

   // byte addresses on the register port
   localparam logic [CSR_ADDR_W-1:0] TOL_ADDR   = {REG_TOLERANCE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = 3'd4;

   // one result transaction as seen on the rsp_ port
   typedef struct packed {
      kind_type           kind;
      logic [ITER_W-1:0]  iteration;
      logic [VAL_W-1:0]   low_bound;
      logic [VAL_W-1:0]   midpoint;
      logic [VAL_W-1:0]   high_bound;
      logic [VAL_W-1:0]   root;
      logic               last;
   } step_type;

   // predicts the bisection trace of each accepted value and checks results in order
   class trace_checker_type;
      step_type         pending_steps[$];
      logic [VAL_W-1:0] tol_reg;
      int               errors;

      function new();
         tol_reg = TOLERANCE_RESET;
         errors  = 0;
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) $display("%s", msg);
      endfunction

      function void add_step(kind_type k, logic [ITER_W-1:0] it, logic [VAL_W-1:0] lo,
                             logic [VAL_W-1:0] mid, logic [VAL_W-1:0] hi,
                             logic [VAL_W-1:0] root, logic fin);
         step_type r;
         r.kind       = k;
         r.iteration  = it;
         r.low_bound  = lo;
         r.midpoint   = mid;
         r.high_bound = hi;
         r.root       = root;
         r.last       = fin;
         pending_steps.push_back(r);
      endfunction

      // whole search for one value, at the current tolerance
      function void note_value(logic [VAL_W-1:0] v);
         logic [SQ_W-1:0]    target, tol, s_est, s_lo, s_hi, diff;
         logic [VAL_W-1:0]   lo, hi, est;
         logic [VAL_W:0]     sum;
         logic [ITER_W-1:0]  step;
         target = {32'b0, v} << FRAC;
         tol    = {32'b0, tol_reg} << FRAC;
         lo     = '0;
         hi     = (v > (32'd1 << FRAC)) ? v : (32'd1 << FRAC);
         sum    = lo + hi;
         est    = sum[VAL_W:1];
         for (step = 0; step < MAX_STEPS; step++) begin
            s_est = est * est;
            s_lo  = lo * lo;
            s_hi  = hi * hi;
            diff  = (s_est >= target) ? s_est - target : target - s_est;
            if (diff <= tol) begin
               add_step(KIND_TOL, step, lo, est, hi, est, 1'b1);
               return;
            end
            if (s_lo == target) begin
               add_step(KIND_EXACT, step, lo, est, hi, lo, 1'b1);
               return;
            end
            if (s_hi == target) begin
               add_step(KIND_EXACT, step, lo, est, hi, hi, 1'b1);
               return;
            end
            add_step(KIND_TRACE, step, lo, est, hi, '0, 1'b0);
            if (s_est < target) lo = est;
            else hi = est;
            sum = lo + hi;
            est = sum[VAL_W:1];
         end
         add_step(KIND_CAP, ITER_W'(MAX_STEPS), lo, est, hi, est, 1'b1);
      endfunction

      function void check_step(step_type got);
         step_type want;
         if (pending_steps.size() == 0) begin
            flag($sformatf("unexpected result: kind %0d it %0d root %h",
                           got.kind, got.iteration, got.root));
            return;
         end
         want = pending_steps.pop_front();
         if (got !== want)
            flag($sformatf({"result mismatch: want kind %0d it %0d lo %h mid %h hi %h ",
                            "root %h last %b / got kind %0d it %0d lo %h mid %h hi %h ",
                            "root %h last %b"},
                           want.kind, want.iteration, want.low_bound, want.midpoint,
                           want.high_bound, want.root, want.last,
                           got.kind, got.iteration, got.low_bound, got.midpoint,
                           got.high_bound, got.root, got.last));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [VAL_W-1:0]      req_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [KIND_W-1:0]     rsp_kind;
   logic [ITER_W-1:0]     rsp_iteration;
   logic [VAL_W-1:0]      rsp_low_bound;
   logic [VAL_W-1:0]      rsp_midpoint;
   logic [VAL_W-1:0]      rsp_high_bound;
   logic [VAL_W-1:0]      rsp_root;
   logic                  rsp_last;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   trace_checker_type sb = new();

   int send_idle = 38;
   int recv_idle = 81;
   bit hold_request = 1'b0;
   int quiet_cycles = 0;

   logic [VAL_W-1:0] corner_values [13] = '{
      32'h0000_0000, 32'h0000_0001, 32'h0000_0100, 32'h0000_4000, 32'h0000_FFFF,
      32'h0001_0000, 32'h0001_0001, 32'h0002_0000, 32'h0004_0000, 32'h0009_0000,
      32'h8000_0000, 32'hFFFE_0001, 32'hFFFF_FFFF
   };
   logic [VAL_W-1:0] zero_tol_values [7] = '{
      32'h0000_0000, 32'h0000_0002, 32'h0000_0004, 32'h0001_0000,
      32'h0002_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF
   };

   bisection_square_root #(
      .MAX_ITER  (MAX_STEPS),
      .FRAC_BITS (FRAC)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_iteration  (rsp_iteration),
      .rsp_low_bound  (rsp_low_bound),
      .rsp_midpoint   (rsp_midpoint),
      .rsp_high_bound (rsp_high_bound),
      .rsp_root       (rsp_root),
      .rsp_last       (rsp_last),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always #10 clock = ~clock;

   // random value: squares, near squares, small and scaled values mixed with plain noise
   function automatic logic [VAL_W-1:0] pick_value();
      logic [15:0]      m;
      logic [VAL_W-1:0] sq_val;
      m      = 16'($urandom_range(0, 16'hFFFF));
      sq_val = m * m;
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 32'h0000_FFFF);
         2: return sq_val;
         3: return sq_val + $urandom_range(0, 4) - 32'd2;
         4: return $urandom >> $urandom_range(0, 31);
         default: return {m, 16'h0000};
      endcase
   endfunction

   // offer one value and wait for the input transaction
   task automatic send_value(input logic [VAL_W-1:0] v);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_value(v);
   endtask

   // let every predicted result arrive, then settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending_steps.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // one transfer on the register port: setup phase, then access phase
   task automatic csr_cycle(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data,
                            output logic [CSR_DATA_W-1:0] rd);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rd = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // write, and read back the tolerance register
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      logic [CSR_DATA_W-1:0] rd;
      csr_cycle(1'b1, addr, data, rd);
      if (addr == TOL_ADDR) begin
         sb.tol_reg = data;
         csr_cycle(1'b0, addr, '0, rd);
         if (rd !== data)
            sb.flag($sformatf("tolerance readback: want %h got %h", data, rd));
      end
   endtask

   // result side: check each output transaction, then pick the next stall
   initial begin : result_sink
      step_type got;
      int       hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.kind       = kind_type'(rsp_kind);
            got.iteration  = rsp_iteration;
            got.low_bound  = rsp_low_bound;
            got.midpoint   = rsp_midpoint;
            got.high_bound = rsp_high_bound;
            got.root       = rsp_root;
            got.last       = rsp_last;
            sb.check_step(got);
         end
         if (hold_request && hold_left == 0) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle);
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // main sequence
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset tolerance, corner values
      foreach (corner_values[i]) send_value(corner_values[i]);
      wait_drained();

      // zero tolerance: exact squares or the iteration cap
      csr_write(TOL_ADDR, 32'h0000_0000);
      foreach (zero_tol_values[i]) send_value(zero_tol_values[i]);
      repeat (110) send_value(pick_value());
      wait_drained();

      // idling swapped, widest tolerance, spare address ignored
      send_idle = 81;
      recv_idle = 38;
      csr_write(SPARE_ADDR, $urandom);
      csr_write(TOL_ADDR, 32'hFFFF_FFFF);
      repeat (60) send_value(pick_value());
      wait_drained();

      csr_write(TOL_ADDR, $urandom);
      repeat (70) send_value(pick_value());
      wait_drained();

      // no idling, long receiver hold so the input backs up
      send_idle = 0;
      recv_idle = 0;
      csr_write(TOL_ADDR, $urandom_range(1, 4096));
      hold_request = 1'b1;
      repeat (70) send_value(pick_value());
      wait_drained();

      if (sb.errors == 0 && sb.pending_steps.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/bsr_pkg.sv
design/bsr_seq.sv
design/bsr_dp.sv
design/bisection_square_root.sv
tb/bisection_square_root_tb.sv
